### rtl/core/dcwcs_pkg.sv
// Shared types and constants for the dual-channel window change selector.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none

package dcwcs_pkg;

   localparam int SAMPLE_W  = 17;
   localparam int RAW_W     = 10;
   localparam int RADIO_W   = 21;
   localparam int WIN_W     = 5;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 17;
   localparam int FRAC_BITS = 16;
   localparam int DIV_CW    = $clog2(FRAC_BITS);

   localparam logic [SAMPLE_W-1:0] ONE_Q16 = 17'd65536;

   localparam logic [RAW_W-1:0]    FULL_SCALE_RST = 10'd1023;
   localparam logic [SAMPLE_W-1:0] THRESHOLD_RST  = 17'd3277;
   localparam logic [WIN_W-1:0]    OLD_WIN_RST    = 5'd8;
   localparam logic [WIN_W-1:0]    NEW_WIN_RST    = 5'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POTI_FULL_SCALE = 3'd0,
      CSR_RADIO_THRESHOLD = 3'd1,
      CSR_POTI_THRESHOLD  = 3'd2,
      CSR_OLD_WINDOW_SIZE = 3'd3,
      CSR_NEW_WINDOW_SIZE = 3'd4,
      CSR_RADIO_ENABLE    = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_WRITE,
      ST_READ,
      ST_DRAIN,
      ST_PRODUCT,
      ST_SCALE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic write_hist;
      logic read_step;
      logic mul;
      logic scale;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic read_last;
      logic out_busy;
   } status_type;

endpackage

`default_nettype wire

### rtl/core/dcwcs_ctrl.sv
// Sequencer for the window change selector: steps one word through divide,
// history write, history walk, products and decision. Uses dcwcs_pkg.
`default_nettype none

module dcwcs_ctrl
   import dcwcs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            if (status.read_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_PRODUCT;
         end
         ST_PRODUCT: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!status.out_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_WRITE: begin
            cmd.write_hist = 1'b1;
         end
         ST_READ: begin
            cmd.read_step = 1'b1;
         end
         ST_PRODUCT: begin
            cmd.mul = 1'b1;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
         end
         ST_DONE: begin
            cmd.finish = !status.out_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/core/dcwcs_datapath.sv
// Datapath of the window change selector: config registers, fraction divider,
// circular history memories, window sums, products and result register. Uses dcwcs_pkg.
`default_nettype none

module dcwcs_datapath
   import dcwcs_pkg::*;
#(
   parameter int HISTORY_DEPTH = 16
)
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_DAT_W-1:0]       csr_wdata,
   input  wire logic [RAW_W-1:0]           req_poti_raw,
   input  wire logic                       req_radio_present,
   input  wire logic signed [RADIO_W-1:0]  req_radio_value,
   input  wire cmd_type                    cmd,
   output status_type                      status,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [SAMPLE_W-1:0]             rsp_target_value,
   output logic                            rsp_radio_changed,
   output logic                            rsp_poti_changed
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam int WW = (CW > WIN_W) ? CW : WIN_W;
   localparam int SW = SAMPLE_W + AW;
   localparam int PW = SW + CW;
   localparam int TW = SAMPLE_W + 2 * CW;
   localparam int HW = SAMPLE_W + CW;

   localparam logic [AW-1:0]     LAST_IDX = AW'(HISTORY_DEPTH - 1);
   localparam logic [CW-1:0]     DEPTH_C  = CW'(HISTORY_DEPTH);
   localparam logic [WW-1:0]     DEPTH_W  = WW'(HISTORY_DEPTH);
   localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(FRAC_BITS - 1);

   // configuration
   logic [RAW_W-1:0]    full_scale_ff;
   logic [SAMPLE_W-1:0] radio_thr_ff;
   logic [SAMPLE_W-1:0] poti_thr_ff;
   logic [WIN_W-1:0]    old_win_ff;
   logic [WIN_W-1:0]    new_win_ff;
   logic                radio_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         full_scale_ff <= FULL_SCALE_RST;
         radio_thr_ff  <= THRESHOLD_RST;
         poti_thr_ff   <= THRESHOLD_RST;
         old_win_ff    <= OLD_WIN_RST;
         new_win_ff    <= NEW_WIN_RST;
         radio_en_ff   <= 1'b1;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_POTI_FULL_SCALE: full_scale_ff <= csr_wdata[RAW_W-1:0];
            CSR_RADIO_THRESHOLD: radio_thr_ff  <= csr_wdata[SAMPLE_W-1:0];
            CSR_POTI_THRESHOLD:  poti_thr_ff   <= csr_wdata[SAMPLE_W-1:0];
            CSR_OLD_WINDOW_SIZE: old_win_ff    <= csr_wdata[WIN_W-1:0];
            CSR_NEW_WINDOW_SIZE: new_win_ff    <= csr_wdata[WIN_W-1:0];
            CSR_RADIO_ENABLE:    radio_en_ff   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   logic [RAW_W-1:0] fs_eff;
   logic [WW-1:0]    old_w_ext;
   logic [WW-1:0]    new_w_ext;
   logic [CW-1:0]    old_n;
   logic [CW-1:0]    new_n;

   assign fs_eff    = (full_scale_ff == '0) ? RAW_W'(1) : full_scale_ff;
   assign old_w_ext = WW'(old_win_ff);
   assign new_w_ext = WW'(new_win_ff);
   assign old_n = (old_w_ext == '0) ? CW'(1) :
                  (old_w_ext > DEPTH_W) ? DEPTH_C : old_w_ext[CW-1:0];
   assign new_n = (new_w_ext == '0) ? CW'(1) :
                  (new_w_ext > DEPTH_W) ? DEPTH_C : new_w_ext[CW-1:0];

   // radio sample and potentiometer fraction
   logic [SAMPLE_W-1:0] newest_r_ff;
   logic [SAMPLE_W-1:0] newest_p_ff;
   logic [SAMPLE_W-1:0] rq_ff;
   logic [SAMPLE_W-1:0] rq_in;
   logic [RAW_W-1:0]    rem_ff;
   logic [FRAC_BITS-1:0] quo_ff;
   logic [DIV_CW-1:0]   div_cnt_ff;
   logic                sat_ff;
   logic [RAW_W:0]      rem2;
   logic [RAW_W:0]      rem_sub;
   logic                rem_ge;
   logic [SAMPLE_W-1:0] pq;

   always_comb begin
      if (radio_en_ff && req_radio_present) begin
         if (req_radio_value < 0) begin
            rq_in = '0;
         end else if (req_radio_value > $signed(RADIO_W'(ONE_Q16))) begin
            rq_in = ONE_Q16;
         end else begin
            rq_in = req_radio_value[SAMPLE_W-1:0];
         end
      end else begin
         rq_in = newest_r_ff;
      end
   end

   assign rem2    = {rem_ff, 1'b0};
   assign rem_ge  = rem2 >= {1'b0, fs_eff};
   assign rem_sub = rem2 - {1'b0, fs_eff};
   assign pq      = sat_ff ? ONE_Q16 : {1'b0, quo_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rq_ff      <= rq_in;
         sat_ff     <= req_poti_raw >= fs_eff;
         rem_ff     <= (req_poti_raw >= fs_eff) ? '0 : req_poti_raw;
         quo_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff     <= rem_ge ? rem_sub[RAW_W-1:0] : rem2[RAW_W-1:0];
         quo_ff     <= {quo_ff[FRAC_BITS-2:0], rem_ge};
         div_cnt_ff <= div_cnt_ff + DIV_CW'(1);
      end
   end

   // history memories, entry at wp_ff - 1 is newest
   logic [SAMPLE_W-1:0] poti_mem  [HISTORY_DEPTH];
   logic [SAMPLE_W-1:0] radio_mem [HISTORY_DEPTH];
   logic [AW-1:0]       wp_ff;
   logic [AW-1:0]       rd_addr_ff;
   logic [AW-1:0]       age_ff;
   logic [CW-1:0]       fill_ff;
   logic [SAMPLE_W-1:0] rd_p_ff;
   logic [SAMPLE_W-1:0] rd_r_ff;
   logic [AW-1:0]       tag_age_ff;
   logic                acc_en_ff;

   always_ff @(posedge clock) begin
      if (cmd.write_hist) begin
         poti_mem[wp_ff]  <= pq;
         radio_mem[wp_ff] <= rq_ff;
      end
      if (cmd.read_step) begin
         rd_p_ff <= poti_mem[rd_addr_ff];
         rd_r_ff <= radio_mem[rd_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         fill_ff     <= '0;
         newest_r_ff <= '0;
         newest_p_ff <= '0;
         acc_en_ff   <= 1'b0;
      end else begin
         acc_en_ff <= cmd.read_step;
         if (cmd.write_hist) begin
            wp_ff       <= (wp_ff == LAST_IDX) ? '0 : wp_ff + AW'(1);
            fill_ff     <= (fill_ff == DEPTH_C) ? fill_ff : fill_ff + CW'(1);
            newest_r_ff <= rq_ff;
            newest_p_ff <= pq;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_hist) begin
         rd_addr_ff <= wp_ff;
         age_ff     <= '0;
      end else if (cmd.read_step) begin
         rd_addr_ff <= (rd_addr_ff == '0) ? LAST_IDX : rd_addr_ff - AW'(1);
         age_ff     <= age_ff + AW'(1);
      end
      if (cmd.read_step) tag_age_ff <= age_ff;
   end

   // window sums
   logic [SW-1:0] p_new_sum_ff;
   logic [SW-1:0] p_old_sum_ff;
   logic [SW-1:0] r_new_sum_ff;
   logic [SW-1:0] r_old_sum_ff;
   logic [CW-1:0] tag_age_c;
   logic          live;
   logic          in_new;
   logic          in_old;

   assign tag_age_c = CW'(tag_age_ff);
   assign live      = tag_age_c < fill_ff;
   assign in_new    = tag_age_c < new_n;
   assign in_old    = tag_age_c >= (DEPTH_C - old_n);

   always_ff @(posedge clock) begin
      if (cmd.write_hist) begin
         p_new_sum_ff <= '0;
         p_old_sum_ff <= '0;
         r_new_sum_ff <= '0;
         r_old_sum_ff <= '0;
      end else if (acc_en_ff && live) begin
         if (in_new) begin
            p_new_sum_ff <= p_new_sum_ff + SW'(rd_p_ff);
            r_new_sum_ff <= r_new_sum_ff + SW'(rd_r_ff);
         end
         if (in_old) begin
            p_old_sum_ff <= p_old_sum_ff + SW'(rd_p_ff);
            r_old_sum_ff <= r_old_sum_ff + SW'(rd_r_ff);
         end
      end
   end

   // cross products and threshold scaling
   logic [PW-1:0] p_a_ff, p_b_ff, r_a_ff, r_b_ff;
   logic [HW-1:0] p_t1_ff, r_t1_ff;
   logic [PW-1:0] p_diff_ff, r_diff_ff;
   logic [TW-1:0] p_t2_ff, r_t2_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         p_a_ff  <= PW'(p_old_sum_ff) * PW'(new_n);
         p_b_ff  <= PW'(p_new_sum_ff) * PW'(old_n);
         r_a_ff  <= PW'(r_old_sum_ff) * PW'(new_n);
         r_b_ff  <= PW'(r_new_sum_ff) * PW'(old_n);
         p_t1_ff <= HW'(poti_thr_ff) * HW'(old_n);
         r_t1_ff <= HW'(radio_thr_ff) * HW'(old_n);
      end
      if (cmd.scale) begin
         p_diff_ff <= (p_a_ff > p_b_ff) ? p_a_ff - p_b_ff : p_b_ff - p_a_ff;
         r_diff_ff <= (r_a_ff > r_b_ff) ? r_a_ff - r_b_ff : r_b_ff - r_a_ff;
         p_t2_ff   <= TW'(p_t1_ff) * TW'(new_n);
         r_t2_ff   <= TW'(r_t1_ff) * TW'(new_n);
      end
   end

   // decision and result word
   logic                radio_ch;
   logic                poti_ch;
   logic [SAMPLE_W-1:0] target_ff;
   logic [SAMPLE_W-1:0] target_in;
   logic                rsp_valid_ff;
   logic                rsp_radio_ff;
   logic                rsp_poti_ff;

   assign radio_ch  = TW'(r_diff_ff) > r_t2_ff;
   assign poti_ch   = TW'(p_diff_ff) > p_t2_ff;
   assign target_in = radio_ch ? newest_r_ff : (poti_ch ? newest_p_ff : target_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            target_ff    <= target_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_radio_ff <= radio_ch;
         rsp_poti_ff  <= poti_ch;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_target_value  = target_ff;
   assign rsp_radio_changed = rsp_radio_ff;
   assign rsp_poti_changed  = rsp_poti_ff;

   assign status.div_last  = div_cnt_ff == DIV_LAST;
   assign status.read_last = age_ff == LAST_IDX;
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

endmodule

`default_nettype wire

### rtl/core/dual_channel_window_change_selector.sv
// Top level of the dual-channel window change selector: joins dcwcs_ctrl and
// dcwcs_datapath. Uses dcwcs_pkg.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  poti_raw, radio_present, radio_value
//   rsp      out        rsp_valid/rsp_ready  target_value, radio_changed, poti_changed
//   csr      in         csr_we               csr_index, csr_wdata
//
// One word passes through sixteen divider steps, then one history read a cycle
// over the whole depth, then products.
// One word is in work at a time; the next is taken once the result is in the
// output register. A stalled rsp side holds that register and the next word.
// Reset is synchronous; history reads as zero until written, via a fill count.
`default_nettype none

module dual_channel_window_change_selector
   import dcwcs_pkg::*;
#(
   parameter int HISTORY_DEPTH = 16
)
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_DAT_W-1:0]       csr_wdata,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [RAW_W-1:0]           req_poti_raw,
   input  wire logic                       req_radio_present,
   input  wire logic signed [RADIO_W-1:0]  req_radio_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [SAMPLE_W-1:0]             rsp_target_value,
   output logic                            rsp_radio_changed,
   output logic                            rsp_poti_changed
);

   cmd_type    cmd;
   status_type status;

   dcwcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dcwcs_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_poti_raw      (req_poti_raw),
      .req_radio_present (req_radio_present),
      .req_radio_value   (req_radio_value),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_target_value  (rsp_target_value),
      .rsp_radio_changed (rsp_radio_changed),
      .rsp_poti_changed  (rsp_poti_changed)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("block took a second word while one was in work");

   a_target_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_target_value <= ONE_Q16)
      else $error("target above one");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result word appeared without an item in work");

endmodule

`default_nettype wire
